// File: rtl/crg_pkg.sv
// shared types and constants of the camera ray generator
package crg_pkg;

	localparam int unsigned LANES = 3;
	localparam int unsigned CW = 30;          // normalized magnitude width
	localparam int unsigned RW = 62;          // radicand width
	localparam int unsigned NW = 31;          // root width
	localparam int unsigned QW = 15;          // quotient width
	localparam logic [QW-1:0] DIR_ONE = 15'd16384;

	localparam logic [2:0] REG_HALF_WIDTH  = 3'd0;
	localparam logic [2:0] REG_HALF_HEIGHT = 3'd1;
	localparam logic [2:0] REG_PIXEL_STEP  = 3'd2;
	localparam logic [2:0] REG_ROW_A       = 3'd3;
	localparam logic [2:0] REG_ROW_B       = 3'd4;
	localparam logic [2:0] REG_ROW_C       = 3'd5;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
	} pixel_t;

	typedef struct packed {
		logic signed [15:0] origin_x;
		logic signed [15:0] origin_y;
		logic signed [15:0] origin_z;
		logic signed [15:0] dir_x;
		logic signed [15:0] dir_y;
		logic signed [15:0] dir_z;
	} ray_t;

	// per-item data that rides alongside the root and divide pipelines
	typedef struct packed {
		logic [LANES-1:0][CW-1:0] mag;
		logic [LANES-1:0]         neg;
		logic                     zero;
	} side_t;

endpackage

// File: rtl/crg_isqrt.sv
// pipelined integer square root, one result bit per stage
module crg_isqrt import crg_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [RW-1:0] radicand,
	input  side_t         side_in,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [NW-1:0] root,
	output side_t         side_out
);

	localparam int S = NW;

	logic          valid_s [S];
	logic [32:0]   rem_s   [S];
	logic [NW-1:0] root_s  [S];
	logic [RW-1:0] rad_s   [S];
	side_t         side_s  [S];
	logic [S:0]    en;

	assign en[S] = out_ready;

	for (genvar j = 0; j < S; j++) begin : g_stage
		logic          v_in;
		logic [32:0]   rem_in;
		logic [NW-1:0] root_in;
		logic [RW-1:0] rad_in;
		side_t         side_in_j;
		logic [32:0]   r;
		logic [32:0]   trial;

		if (j == 0) begin : g_first
			assign v_in      = in_valid;
			assign rem_in    = '0;
			assign root_in   = '0;
			assign rad_in    = radicand;
			assign side_in_j = side_in;
		end else begin : g_next
			assign v_in      = valid_s[j-1];
			assign rem_in    = rem_s[j-1];
			assign root_in   = root_s[j-1];
			assign rad_in    = rad_s[j-1];
			assign side_in_j = side_s[j-1];
		end

		assign en[j] = !valid_s[j] || en[j+1];
		assign r     = {rem_in[30:0], rad_in[RW-1-2*j -: 2]};
		assign trial = {root_in, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (en[j]) begin
				valid_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				if (r >= trial) begin
					rem_s[j]  <= r - trial;
					root_s[j] <= {root_in[NW-2:0], 1'b1};
				end else begin
					rem_s[j]  <= r;
					root_s[j] <= {root_in[NW-2:0], 1'b0};
				end
				rad_s[j]  <= rad_in;
				side_s[j] <= side_in_j;
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_s[S-1];
	assign root      = root_s[S-1];
	assign side_out  = side_s[S-1];

endmodule

// File: rtl/crg_div.sv
// pipelined restoring divide of three lanes by twice the root, rounded half up
module crg_div import crg_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [NW-1:0]                n,
	input  side_t                        side_in,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [LANES-1:0][15:0]       dir
);

	localparam int S = QW + 1;

	logic                       valid_s [S];
	logic [LANES-1:0][45:0]     rem_s   [S];
	logic [LANES-1:0][QW-1:0]   quo_s   [S];
	logic [31:0]                den_s   [S];
	logic [LANES-1:0]           neg_s   [S];
	logic                       zero_s  [S];
	logic [S:0]                 en;

	assign en[S] = out_ready;

	// setup stage: numerator c*2^15 + n, denominator 2n
	assign en[0] = !valid_s[0] || en[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en[0]) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int l = 0; l < LANES; l++) begin
				rem_s[0][l] <= {1'b0, side_in.mag[l], 15'd0} + {15'd0, n};
			end
			quo_s[0]  <= '0;
			den_s[0]  <= {n, 1'b0};
			neg_s[0]  <= side_in.neg;
			zero_s[0] <= side_in.zero;
		end
	end

	for (genvar j = 1; j < S; j++) begin : g_stage
		localparam int B = S - 1 - j;
		logic [46:0] trial;

		assign en[j] = !valid_s[j] || en[j+1];
		assign trial = {15'd0, den_s[j-1]} << B;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[j] <= 1'b0;
			end else if (en[j]) begin
				valid_s[j] <= valid_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				for (int l = 0; l < LANES; l++) begin
					if ({1'b0, rem_s[j-1][l]} >= trial) begin
						rem_s[j][l]    <= rem_s[j-1][l] - trial[45:0];
						quo_s[j][l]    <= quo_s[j-1][l] | (QW'(1) << B);
					end else begin
						rem_s[j][l]    <= rem_s[j-1][l];
						quo_s[j][l]    <= quo_s[j-1][l];
					end
				end
				den_s[j]  <= den_s[j-1];
				neg_s[j]  <= neg_s[j-1];
				zero_s[j] <= zero_s[j-1];
			end
		end
	end

	always_comb begin
		logic [QW-1:0] q;
		for (int l = 0; l < LANES; l++) begin
			q = (quo_s[S-1][l] > DIR_ONE) ? DIR_ONE : quo_s[S-1][l];
			if (zero_s[S-1]) begin
				dir[l] = '0;
			end else if (neg_s[S-1][l]) begin
				dir[l] = -{1'b0, q};
			end else begin
				dir[l] = {1'b0, q};
			end
		end
	end

	assign in_ready  = en[0];
	assign out_valid = valid_s[S-1];

endmodule

// File: rtl/camera_ray_generation.sv
// top level of the pinhole camera ray generator
//
// takes one pixel item per cycle and returns one ray item per pixel, in order. the ray
// origin is the translation column of the inverse camera transform and the direction is
// the linear part times the view-plane point, scaled to unit length in Q1.14. the pipeline is
// 11 front stages (plane point, transform multiply, sum, magnitude, normalize, squares),
// 31 square-root stages, 16 divide stages and the output register. one item enters every
// cycle when the output is not stalled; a stall holds back only stages that are full, so
// empty slots close up first. configuration registers are written through an always-ready
// write port and must only change while no item is in flight.
module camera_ray_generation import crg_pkg::*; #(
	parameter int MAX_DIM = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pixel_valid,
	output logic        pixel_stall,
	input  pixel_t      pixel,
	output logic        ray_valid,
	input  logic        ray_stall,
	output ray_t        ray,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	localparam int FS = 11;  // front stages

	// configuration registers
	logic [31:0] half_width_q, half_height_q, pixel_step_q;
	logic [LANES-1:0][63:0] row_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_width_q  <= 32'd16777216;
			half_height_q <= 32'd16777216;
			pixel_step_q  <= 32'd16384;
			row_q[0]      <= 64'h0000_0000_0000_1000;
			row_q[1]      <= 64'h0000_0000_1000_0000;
			row_q[2]      <= 64'h0000_1000_0000_0000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HALF_WIDTH:  half_width_q  <= cfg_data[31:0];
				REG_HALF_HEIGHT: half_height_q <= cfg_data[31:0];
				REG_PIXEL_STEP:  pixel_step_q  <= cfg_data[31:0];
				REG_ROW_A:       row_q[0]      <= cfg_data;
				REG_ROW_B:       row_q[1]      <= cfg_data;
				REG_ROW_C:       row_q[2]      <= cfg_data;
				default: ;
			endcase
		end
	end

	// front pipeline valid bits and stall chain
	logic        valid_s [1:FS];
	logic [1:FS+1] en;
	logic        isq_ready;

	assign en[FS+1]    = isq_ready;
	assign pixel_stall = !en[1];

	for (genvar i = 1; i <= FS; i++) begin : g_valid
		logic v_in;
		if (i == 1) begin : g_first
			assign v_in = pixel_valid;
		end else begin : g_next
			assign v_in = valid_s[i-1];
		end
		assign en[i] = !valid_s[i] || en[i+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i] <= 1'b0;
			end else if (en[i]) begin
				valid_s[i] <= v_in;
			end
		end
	end

	// s1: clamp pixel and scale (2*idx + 1) by the pixel step
	logic [11:0] x_clamp, y_clamp;
	logic [44:0] a_s1, b_s1;

	always_comb begin
		x_clamp = pixel.pixel_x;
		y_clamp = pixel.pixel_y;
		if ({5'd0, pixel.pixel_x} >= 17'(MAX_DIM)) begin
			x_clamp = 12'(MAX_DIM - 1);
		end
		if ({5'd0, pixel.pixel_y} >= 17'(MAX_DIM)) begin
			y_clamp = 12'(MAX_DIM - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			a_s1 <= 45'({x_clamp, 1'b1}) * 45'(pixel_step_q);
			b_s1 <= 45'({y_clamp, 1'b1}) * 45'(pixel_step_q);
		end
	end

	// s2: plane point in signed Q.25
	logic signed [46:0] px_s2, py_s2;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			px_s2 <= $signed({14'd0, half_width_q, 1'b0}) - $signed({2'd0, a_s1});
			py_s2 <= $signed({14'd0, half_height_q, 1'b0}) - $signed({2'd0, b_s1});
		end
	end

	// s3: linear entries of columns 0 and 1 times the plane point
	logic signed [62:0] pa_s3 [LANES];
	logic signed [62:0] pb_s3 [LANES];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int l = 0; l < LANES; l++) begin
				pa_s3[l] <= 63'($signed(row_q[l][15:0])) * 63'(px_s2);
				pb_s3[l] <= 63'($signed(row_q[l][31:16])) * 63'(py_s2);
			end
		end
	end

	// s4: raw direction, z of the plane point is -1 so column 2 enters negated
	logic signed [63:0] d_s4 [LANES];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int l = 0; l < LANES; l++) begin
				d_s4[l] <= 64'(pa_s3[l]) + 64'(pb_s3[l])
					- (64'($signed(row_q[l][47:32])) <<< 25);
			end
		end
	end

	// s5: sign and magnitude
	logic [RW-1:0]    mag_s5 [LANES];
	logic [LANES-1:0] neg_s5;

	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int l = 0; l < LANES; l++) begin
				logic [63:0] nd;
				nd = -d_s4[l];
				neg_s5[l] <= d_s4[l][63];
				mag_s5[l] <= d_s4[l][63] ? nd[RW-1:0] : d_s4[l][RW-1:0];
			end
		end
	end

	// s6: largest magnitude
	logic [RW-1:0]    mag_s6 [LANES];
	logic [LANES-1:0] neg_s6;
	logic [RW-1:0]    m_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			logic [RW-1:0] m;
			m = mag_s5[0];
			for (int l = 1; l < LANES; l++) begin
				if (mag_s5[l] > m) begin
					m = mag_s5[l];
				end
			end
			m_s6   <= m;
			mag_s6 <= mag_s5;
			neg_s6 <= neg_s5;
		end
	end

	// s7: leading one within each byte
	logic [RW-1:0]    mag_s7 [LANES];
	logic [LANES-1:0] neg_s7;
	logic [7:0]       gnz_s7;
	logic [7:0][2:0]  gpos_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			logic [63:0] mw;
			logic [2:0]  p;
			mw = {2'b00, m_s6};
			for (int g = 0; g < 8; g++) begin
				p = '0;
				for (int b = 0; b < 8; b++) begin
					if (mw[8*g+b]) begin
						p = 3'(b);
					end
				end
				gnz_s7[g]  <= |mw[8*g +: 8];
				gpos_s7[g] <= p;
			end
			mag_s7 <= mag_s6;
			neg_s7 <= neg_s6;
		end
	end

	// s8: bit length of the largest magnitude
	logic [RW-1:0]    mag_s8 [LANES];
	logic [LANES-1:0] neg_s8;
	logic [6:0]       k_s8;
	logic             zero_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			logic [6:0] k;
			k = '0;
			for (int g = 0; g < 8; g++) begin
				if (gnz_s7[g]) begin
					k = 7'({3'(g), gpos_s7[g]}) + 7'd1;
				end
			end
			k_s8    <= k;
			zero_s8 <= ~|gnz_s7;
			mag_s8  <= mag_s7;
			neg_s8  <= neg_s7;
		end
	end

	// s9: scale so the largest magnitude fills 30 bits
	logic [CW-1:0]    c_s9 [LANES];
	logic [LANES-1:0] neg_s9;
	logic             zero_s9;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			logic [RW-1:0] t;
			for (int l = 0; l < LANES; l++) begin
				if (k_s8 > 7'd30) begin
					t = mag_s8[l] >> (k_s8 - 7'd30);
				end else begin
					t = mag_s8[l] << (7'd30 - k_s8);
				end
				c_s9[l] <= t[CW-1:0];
			end
			neg_s9  <= neg_s8;
			zero_s9 <= zero_s8;
		end
	end

	// s10: squares
	logic [2*CW-1:0]  sq_s10 [LANES];
	logic [CW-1:0]    c_s10  [LANES];
	logic [LANES-1:0] neg_s10;
	logic             zero_s10;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			for (int l = 0; l < LANES; l++) begin
				sq_s10[l] <= 60'(c_s9[l]) * 60'(c_s9[l]);
			end
			c_s10    <= c_s9;
			neg_s10  <= neg_s9;
			zero_s10 <= zero_s9;
		end
	end

	// s11: sum of squares
	logic [RW-1:0] sum_s11;
	side_t         side_s11;

	always_ff @(posedge clk) begin
		if (en[11]) begin
			sum_s11 <= RW'(sq_s10[0]) + RW'(sq_s10[1]) + RW'(sq_s10[2]);
			for (int l = 0; l < LANES; l++) begin
				side_s11.mag[l] <= c_s10[l];
			end
			side_s11.neg  <= neg_s10;
			side_s11.zero <= zero_s10;
		end
	end

	// length and divide
	logic          isq_valid, div_ready, div_valid, out_en;
	logic [NW-1:0] isq_root;
	side_t         isq_side;
	logic [LANES-1:0][15:0] div_dir;

	crg_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s[FS]),
		.in_ready  (isq_ready),
		.radicand  (sum_s11),
		.side_in   (side_s11),
		.out_valid (isq_valid),
		.out_ready (div_ready),
		.root      (isq_root),
		.side_out  (isq_side)
	);

	crg_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (isq_valid),
		.in_ready  (div_ready),
		.n         (isq_root),
		.side_in   (isq_side),
		.out_valid (div_valid),
		.out_ready (out_en),
		.dir       (div_dir)
	);

	// output register
	logic valid_q;
	ray_t ray_q;

	assign out_en = !valid_q || !ray_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_en) begin
			valid_q <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			ray_q.origin_x <= row_q[0][63:48];
			ray_q.origin_y <= row_q[1][63:48];
			ray_q.origin_z <= row_q[2][63:48];
			ray_q.dir_x    <= div_dir[0];
			ray_q.dir_y    <= div_dir[1];
			ray_q.dir_z    <= div_dir[2];
		end
	end

	assign ray_valid = valid_q;
	assign ray       = ray_q;

`ifndef ASSERT_OFF
	// normalization puts the largest component into the top bit
	a_norm_top: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s[9] && !zero_s9 |-> (c_s9[0][CW-1] || c_s9[1][CW-1] || c_s9[2][CW-1]))
		else $error("normalized magnitude missing its top bit");

	// the length of a normalized nonzero vector is at least 2^29
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		isq_valid && !isq_side.zero |-> isq_root[NW-1:NW-2] != 2'b00)
		else $error("vector length below normalized range");

	// a unit direction never exceeds one in any component
	a_dir_unit: assert property (@(posedge clk) disable iff (!arst_n)
		ray_valid |-> (ray.dir_x <= 16'sd16384) && (ray.dir_x >= -16'sd16384)
			&& (ray.dir_y <= 16'sd16384) && (ray.dir_y >= -16'sd16384)
			&& (ray.dir_z <= 16'sd16384) && (ray.dir_z >= -16'sd16384))
		else $error("direction component out of unit range");
`endif

endmodule

// File: bench/camera_ray_generation_test.sv
// self-checking bench for the camera ray generator: predicted rays against the block's output
module camera_ray_generation_test;
	import crg_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	// predicted rays in acceptance order, compared with each ray item taken from the block
	class ray_scoreboard;
		ray_t pending[$];
		int unsigned mismatches;
		int unsigned matched;

		function void note_pixel(ray_t r);
			pending.push_back(r);
		endfunction

		function void check_ray(ray_t got);
			ray_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected ray item %h", got);
				return;
			end
			want = pending.pop_front();
			if (want !== got) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ray mismatch: expected %h actual %h", want, got);
			end else begin
				matched++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        pixel_valid = 1'b0;
	logic        pixel_stall;
	pixel_t      pixel = '0;
	logic        ray_valid;
	logic        ray_stall = 1'b0;
	ray_t        ray;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;

	localparam int DRAIN_CYCLES = 80;      // extra wait after the last pending ray is seen
	localparam int WATCHDOG_LIMIT = 4000;

	// predictor's copy of the registers
	logic [31:0] hw_q, hh_q, step_q;
	logic [63:0] rows_q [3];

	ray_scoreboard board;
	bit stall_free;     // true during the stretch with no idling
	bit sink_hold;      // output side stalls harder in one phase
	int unsigned idle_cycles;
	int unsigned cfg_writes;

	camera_ray_generation #(.MAX_DIM(4096)) dut (.*);

	always #5 clk = ~clk;

	function automatic logic [63:0] isqrt_u(logic [63:0] s);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > s) bitv >>= 2;
		while (bitv != 0) begin
			if (s >= res + bitv) begin
				s -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// expected ray for a pixel under the current register copy
	function automatic ray_t trace_pixel(pixel_t px_in);
		ray_t r;
		longint signed pt [3];
		longint signed d;
		logic [63:0] mag [3];
		logic [63:0] m, t, sum, n, q;
		bit neg [3];
		int k;
		logic [63:0] x, y;
		logic [15:0] dir [3];
		logic [15:0] org [3];
		x = px_in.pixel_x;   // 12-bit index never exceeds MAX_DIM-1 at MAX_DIM 4096
		y = px_in.pixel_y;
		pt[0] = longint'({32'd0, hw_q}) * 2 - longint'((2 * x + 1) * {32'd0, step_q});
		pt[1] = longint'({32'd0, hh_q}) * 2 - longint'((2 * y + 1) * {32'd0, step_q});
		pt[2] = -(longint'(1) << 25);
		m = 0;
		for (int i = 0; i < 3; i++) begin
			d = longint'($signed(rows_q[i][15:0])) * pt[0]
				+ longint'($signed(rows_q[i][31:16])) * pt[1]
				+ longint'($signed(rows_q[i][47:32])) * pt[2];
			neg[i] = d < 0;
			mag[i] = neg[i] ? -d : d;
			if (mag[i] > m) m = mag[i];
			org[i] = rows_q[i][63:48];
		end
		if (m == 0) begin
			dir[0] = 0; dir[1] = 0; dir[2] = 0;
		end else begin
			k = 0;
			t = m;
			while (t != 0) begin k++; t >>= 1; end
			sum = 0;
			for (int i = 0; i < 3; i++) begin
				if (k > 30) mag[i] >>= (k - 30);
				else mag[i] <<= (30 - k);
				sum += mag[i] * mag[i];
			end
			n = isqrt_u(sum);
			for (int i = 0; i < 3; i++) begin
				q = ((mag[i] << 15) + n) / (2 * n);
				if (q > 16384) q = 16384;
				dir[i] = neg[i] ? 16'(-q) : 16'(q);
			end
		end
		r.origin_x = org[0]; r.origin_y = org[1]; r.origin_z = org[2];
		r.dir_x = dir[0]; r.dir_y = dir[1]; r.dir_z = dir[2];
		return r;
	endfunction

	// output side: random stall, checked on each accepted ray item
	always @(posedge clk) begin
		if (arst_n) begin
			if (ray_valid && !ray_stall)
				board.check_ray(ray);
			if (stall_free) ray_stall <= 1'b0;
			else ray_stall <= ($urandom_range(99) < (sink_hold ? 40 : 12));
		end
	end

	// watchdog on cycles with no accepted item of any kind
	always @(posedge clk) begin
		if ((pixel_valid && !pixel_stall) || (ray_valid && !ray_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("watchdog expired with %0d rays pending", board.pending.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// write one register while the pipeline is empty
	task automatic write_reg(logic [2:0] idx, logic [63:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_HALF_WIDTH:  hw_q = val[31:0];
			REG_HALF_HEIGHT: hh_q = val[31:0];
			REG_PIXEL_STEP:  step_q = val[31:0];
			REG_ROW_A:       rows_q[0] = val;
			REG_ROW_B:       rows_q[1] = val;
			REG_ROW_C:       rows_q[2] = val;
			default: ;
		endcase
		cfg_writes++;
	endtask

	// offer one pixel item, optionally after a random gap, and hold it until taken
	task automatic send_pixel(pixel_t p);
		if (!stall_free) begin
			while ($urandom_range(99) < 12) begin
				pixel_valid <= 1'b0;
				@(posedge clk);
			end
		end
		pixel_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (pixel_stall);
		board.note_pixel(trace_pixel(p));
	endtask

	// stop offering and wait for every pending ray, then let the pipeline settle
	task automatic drain();
		pixel_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [15:0] rand_lin();
		// mostly moderate linear entries, sometimes any 16-bit pattern
		if ($urandom_range(3) == 0) return 16'($urandom());
		return 16'($signed($urandom_range(16384)) - 8192);
	endfunction

	function automatic logic [63:0] rand_row();
		return {16'($urandom()), rand_lin(), rand_lin(), rand_lin()};
	endfunction

	// plane size: mostly moderate, sometimes any 32-bit pattern
	function automatic logic [63:0] rand_size(logic [31:0] top);
		if ($urandom_range(3) == 0) return 64'($urandom());
		return 64'($urandom_range(top));
	endfunction

	task automatic random_pixels(int count);
		pixel_t p;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(9))
				0: p = '{pixel_x: 12'hfff, pixel_y: 12'($urandom())};
				1: p = '{pixel_x: 12'($urandom()), pixel_y: 12'h000};
				2, 3, 4: p = '{pixel_x: 12'($urandom_range(63)),
					pixel_y: 12'($urandom_range(63))};
				default: p = '{pixel_x: 12'($urandom()), pixel_y: 12'($urandom())};
			endcase
			send_pixel(p);
		end
	endtask

	initial begin
		board = new();
		stall_free = 1'b0;
		sink_hold = 1'b0;
		idle_cycles = 0;
		cfg_writes = 0;
		// reset values, the identity transform
		hw_q = 32'd16777216; hh_q = 32'd16777216; step_q = 32'd16384;
		rows_q[0] = 64'd4096; rows_q[1] = 64'd268435456; rows_q[2] = 64'd17592186044416;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: corners and center under reset registers
		send_pixel('{pixel_x: 12'd0, pixel_y: 12'd0});
		send_pixel('{pixel_x: 12'hfff, pixel_y: 12'hfff});
		send_pixel('{pixel_x: 12'd0, pixel_y: 12'hfff});
		send_pixel('{pixel_x: 12'hfff, pixel_y: 12'd0});
		send_pixel('{pixel_x: 12'd1023, pixel_y: 12'd1024});
		send_pixel('{pixel_x: 12'haaa, pixel_y: 12'h555});
		drain();

		// zero direction: all-zero linear part, translation kept
		write_reg(REG_ROW_A, 64'h7fff_0000_0000_0000);
		write_reg(REG_ROW_B, 64'h8000_0000_0000_0000);
		write_reg(REG_ROW_C, 64'hffff_0000_0000_0000);
		send_pixel('{pixel_x: 12'd5, pixel_y: 12'd7});
		send_pixel('{pixel_x: 12'hfff, pixel_y: 12'hfff});
		drain();

		// extreme registers: all ones sizes and step with extreme entries, then zero sizes and step
		write_reg(REG_HALF_WIDTH, 64'hffff_ffff);
		write_reg(REG_HALF_HEIGHT, 64'hffff_ffff);
		write_reg(REG_PIXEL_STEP, 64'hffff_ffff);
		write_reg(REG_ROW_A, 64'h7fff_7fff_8000_7fff);
		write_reg(REG_ROW_B, 64'h8000_8000_7fff_8000);
		write_reg(REG_ROW_C, 64'hffff_ffff_ffff_ffff);
		for (int i = 0; i < 6; i++)
			send_pixel('{pixel_x: 12'($urandom()), pixel_y: 12'($urandom())});
		send_pixel('{pixel_x: 12'hfff, pixel_y: 12'hfff});
		drain();
		write_reg(REG_HALF_WIDTH, 64'd0);
		write_reg(REG_HALF_HEIGHT, 64'd0);
		write_reg(REG_PIXEL_STEP, 64'd0);
		send_pixel('{pixel_x: 12'd0, pixel_y: 12'd0});
		send_pixel('{pixel_x: 12'd3000, pixel_y: 12'd17});
		drain();

		// random phases with fresh registers; a long no-idle stretch and a heavy-stall one
		for (int ph = 0; ph < 8; ph++) begin
			write_reg(REG_HALF_WIDTH, rand_size(32'h0400_0000));
			write_reg(REG_HALF_HEIGHT, rand_size(32'h0400_0000));
			write_reg(REG_PIXEL_STEP, rand_size(32'h0008_0000));
			write_reg(REG_ROW_A, rand_row());
			write_reg(REG_ROW_B, rand_row());
			write_reg(REG_ROW_C, rand_row());
			stall_free = (ph == 2);
			sink_hold = (ph == 5);
			random_pixels(200);
			drain();
		end
		stall_free = 1'b0;
		sink_hold = 1'b0;

		// back to reset-like identity for a final pass
		write_reg(REG_HALF_WIDTH, 64'd16777216);
		write_reg(REG_HALF_HEIGHT, 64'd16777216);
		write_reg(REG_PIXEL_STEP, 64'd16384);
		write_reg(REG_ROW_A, 64'd4096);
		write_reg(REG_ROW_B, 64'd268435456);
		write_reg(REG_ROW_C, 64'd17592186044416);
		random_pixels(60);
		drain();

		$display("covered %0d rays and %0d register writes across directed and random phases",
			board.matched + board.mismatches, cfg_writes);
		if (board.mismatches == 0 && board.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("%0d mismatches, %0d rays never seen", board.mismatches, board.pending.size());
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// File: files.f
rtl/crg_pkg.sv
rtl/crg_isqrt.sv
rtl/crg_div.sv
rtl/camera_ray_generation.sv
bench/camera_ray_generation_test.sv
